>>> rtl/pidpc_pkg.sv
// Package for the PID position controller: fixed-point format, datapath widths
// and configuration register indexes. No dependencies.
package pidpc_pkg;

    // Fraction bits of the Q16.16 gains.
    localparam int GAIN_FRAC_BITS = 16;

    localparam int POS_W   = 31;  // position fields
    localparam int ERR_W   = 32;  // error, always fits in 32 signed bits
    localparam int DER_W   = 33;  // derivative
    localparam int INTEG_W = 40;  // saturating integral
    localparam int GAIN_W  = 32;
    localparam int BAND_W  = 16;
    localparam int DRIVE_W = 16;
    localparam int IHI_W   = INTEG_W - ERR_W;  // upper integral slice

    localparam int PROD_P_W   = ERR_W + GAIN_W;         // 64
    localparam int PROD_ILO_W = ERR_W + 1 + GAIN_W;     // 65
    localparam int PROD_IHI_W = IHI_W + GAIN_W;         // 40
    localparam int PROD_D_W   = DER_W + GAIN_W;         // 65
    localparam int SUM_W      = INTEG_W + GAIN_W + 2;   // 74

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    localparam logic [SUM_W-1:0] FRAC_MASK =
        (SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] DRIVE_MAX = 32767;
    localparam logic signed [SUM_W-1:0] DRIVE_MIN = -32768;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND   = 2'd3;

endpackage

>>> rtl/pid_position_controller.sv
// PID position controller with integral band reset, pipelined datapath.
// Depends on pidpc_pkg.
//
// Usage:
// The s_ channel carries one item per control tick: target and measured
// position. The m_ channel returns one drive_power item for each input item,
// in order. Gains and the integral band are written through the cfg_ port
// (index 0..3: gain_p, gain_i, gain_d, integral_band), by the user only while
// the block is idle; the block itself does not enforce this. cfg_ready is
// always high. Throughput is one item per cycle while m_ready is high:
// five register stages (input, error/integral, multipliers, sum, output)
// advance together. The integral and last error update as an item leaves
// the input stage, so that 40-bit add and clamp is the only feedback.
// When the receiver holds m_ready low, each stage fills in turn and s_ready
// drops once the input stage cannot advance; no item is dropped.
// A synchronous low aresetn clears the gains, band, integral, last error and
// all valid bits.
module pid_position_controller
    import pidpc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [POS_W-1:0]   s_target_position,
    input  logic signed [POS_W-1:0]   s_measured_position,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_drive_power,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [GAIN_W-1:0]         cfg_data
);

    // Configuration registers.
    logic signed [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [BAND_W-1:0]        band_reg;

    // Controller state.
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   last_err_reg;

    // Stage valids.
    logic v0_reg, v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic adv0, adv1, adv2, adv3, acc_in;
    logic rdy1, rdy2, rdy3, out_free;

    // Stage payloads.
    logic signed [POS_W-1:0]      tgt_reg, meas_reg;
    logic signed [ERR_W-1:0]      err1_reg;
    logic signed [INTEG_W-1:0]    integ1_reg;
    logic signed [DER_W-1:0]      der1_reg;
    logic signed [PROD_P_W-1:0]   prod_p_reg;
    logic signed [PROD_ILO_W-1:0] prod_ilo_reg;
    logic signed [PROD_IHI_W-1:0] prod_ihi_reg;
    logic signed [PROD_D_W-1:0]   prod_d_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [DRIVE_W-1:0]    drive_reg, drive_next;

    // Combinational datapath signals.
    logic signed [ERR_W-1:0]      err;
    logic [ERR_W-1:0]             abs_err;
    logic signed [INTEG_W:0]      integ_sum;
    logic signed [INTEG_W-1:0]    integ_sat;
    logic signed [DER_W-1:0]      der;
    logic signed [ERR_W:0]        ilo_op;
    logic signed [PROD_P_W-1:0]   prod_p_next;
    logic signed [PROD_ILO_W-1:0] prod_ilo_next;
    logic signed [PROD_IHI_W-1:0] prod_ihi_next;
    logic signed [PROD_D_W-1:0]   prod_d_next;
    logic signed [SUM_W-1:0]      sum_next;
    logic signed [SUM_W-1:0]      quot, trunc;
    logic                         round_up;

    function automatic logic signed [ERR_W-1:0] s_ext(input logic signed [POS_W-1:0] v);
        return {v[POS_W-1], v};
    endfunction

    // Handshake and stage advance.
    assign out_free = !out_valid_reg || m_ready;
    assign adv3     = v3_reg && out_free;
    assign rdy3     = !v3_reg || out_free;
    assign adv2     = v2_reg && rdy3;
    assign rdy2     = !v2_reg || rdy3;
    assign adv1     = v1_reg && rdy2;
    assign rdy1     = !v1_reg || rdy2;
    assign adv0     = v0_reg && rdy1;
    assign s_ready  = !v0_reg || rdy1;
    assign acc_in   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid       = out_valid_reg;
    assign m_drive_power = drive_reg;

    // Error, integral and derivative from the input stage.
    always_comb begin
        err       = ERR_W'(s_ext(tgt_reg)) - ERR_W'(s_ext(meas_reg));
        abs_err   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        integ_sum = {integ_reg[INTEG_W-1], integ_reg}
                  + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
        // The integral only survives while the error is nonzero and in band.
        if (err == '0 || abs_err > {{(ERR_W-BAND_W){1'b0}}, band_reg}) begin
            integ_next = '0;
        end else begin
            integ_next = integ_sat;
        end
        der = {err[ERR_W-1], err} - {last_err_reg[ERR_W-1], last_err_reg};
    end

    // Multipliers. The 40-bit integral is split into a signed upper byte and
    // an unsigned lower word to keep each product near 32 by 32.
    always_comb begin
        ilo_op        = {1'b0, integ1_reg[ERR_W-1:0]};
        prod_p_next   = err1_reg * gain_p_reg;
        prod_ilo_next = ilo_op * gain_i_reg;
        prod_ihi_next = $signed(integ1_reg[INTEG_W-1:ERR_W]) * gain_i_reg;
        prod_d_next   = der1_reg * gain_d_reg;
    end

    // Exact sum of all terms.
    always_comb begin
        sum_next = {{(SUM_W-PROD_P_W){prod_p_reg[PROD_P_W-1]}}, prod_p_reg}
                 + {{(SUM_W-PROD_IHI_W-ERR_W){prod_ihi_reg[PROD_IHI_W-1]}},
                    prod_ihi_reg, {ERR_W{1'b0}}}
                 + {{(SUM_W-PROD_ILO_W){prod_ilo_reg[PROD_ILO_W-1]}}, prod_ilo_reg}
                 + {{(SUM_W-PROD_D_W){prod_d_reg[PROD_D_W-1]}}, prod_d_reg};
    end

    // Drop the fraction toward zero, then saturate to the output range.
    always_comb begin
        quot     = sum_reg >>> GAIN_FRAC_BITS;
        round_up = sum_reg[SUM_W-1] && ((sum_reg & FRAC_MASK) != '0);
        trunc    = quot + {{(SUM_W-1){1'b0}}, round_up};
        if (trunc > DRIVE_MAX) begin
            drive_next = DRIVE_MAX[DRIVE_W-1:0];
        end else if (trunc < DRIVE_MIN) begin
            drive_next = DRIVE_MIN[DRIVE_W-1:0];
        end else begin
            drive_next = trunc[DRIVE_W-1:0];
        end
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            band_reg      <= '0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_GAIN_P: gain_p_reg <= cfg_data;
                    REG_GAIN_I: gain_i_reg <= cfg_data;
                    REG_GAIN_D: gain_d_reg <= cfg_data;
                    REG_BAND:   band_reg   <= cfg_data[BAND_W-1:0];
                    default:    ;
                endcase
            end
            if (adv0) begin
                integ_reg    <= integ_next;
                last_err_reg <= err;
            end
            if (acc_in)       v0_reg <= 1'b1;
            else if (adv0)    v0_reg <= 1'b0;
            if (adv0)         v1_reg <= 1'b1;
            else if (adv1)    v1_reg <= 1'b0;
            if (adv1)         v2_reg <= 1'b1;
            else if (adv2)    v2_reg <= 1'b0;
            if (adv2)         v3_reg <= 1'b1;
            else if (adv3)    v3_reg <= 1'b0;
            if (adv3)         out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            tgt_reg  <= s_target_position;
            meas_reg <= s_measured_position;
        end
        if (adv0) begin
            err1_reg   <= err;
            integ1_reg <= integ_next;
            der1_reg   <= der;
        end
        if (adv1) begin
            prod_p_reg   <= prod_p_next;
            prod_ilo_reg <= prod_ilo_next;
            prod_ihi_reg <= prod_ihi_next;
            prod_d_reg   <= prod_d_next;
        end
        if (adv2) begin
            sum_reg <= sum_next;
        end
        if (adv3) begin
            drive_reg <= drive_next;
        end
    end

`ifndef ASSERT_OFF
    // A zero error always clears the integral.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (last_err_reg == '0) |-> (integ_reg == '0))
        else $error("integral nonzero after a zero error");

    // State moves only when an item leaves the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v0_reg && !adv0) |=> ($stable(integ_reg) && $stable(last_err_reg)))
        else $error("controller state changed without an item");

    // The output keeps the sign of the sum, or truncates to zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv3 |=> ((m_drive_power[DRIVE_W-1] == $past(sum_reg[SUM_W-1]))
                  || (m_drive_power == '0)))
        else $error("drive sign differs from sum sign");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for pid_position_controller. It drives position items and gain
// settings, predicts every drive_power item and checks it in order. Depends on pidpc_pkg.
module tb_top;
    import pidpc_pkg::*;

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [DRIVE_W-1:0] drive_t;
    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [GAIN_W-1:0]    data;
        pos_t                 target;
        pos_t                 measured;
        bit                   known;
        drive_t               drive;
    } dir_row_t;

    localparam pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 32'h0001_0000;
    localparam logic [GAIN_W-1:0] GAIN_HALF = 32'h0000_8000;
    localparam logic [GAIN_W-1:0] GAIN_NEG1 = 32'hFFFF_0000;
    localparam logic [GAIN_W-1:0] GAIN_MAX  = 32'h7FFF_FFFF;
    localparam logic [GAIN_W-1:0] GAIN_MIN  = 32'h8000_0000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 130;
    localparam int MAX_PRINTED    = 50;

    logic                 aclk;
    logic                 aresetn             = 1'b0;
    logic                 s_valid             = 1'b0;
    logic                 s_ready;
    pos_t                 s_target_position   = '0;
    pos_t                 s_measured_position = '0;
    logic                 m_valid;
    logic                 m_ready             = 1'b0;
    drive_t               m_drive_power;
    logic                 cfg_valid           = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index           = '0;
    logic [GAIN_W-1:0]    cfg_data            = '0;

    // Shadow of the controller: gains, band, integral and last error.
    logic signed [GAIN_W-1:0]  gain_p_q   = '0;
    logic signed [GAIN_W-1:0]  gain_i_q   = '0;
    logic signed [GAIN_W-1:0]  gain_d_q   = '0;
    logic        [BAND_W-1:0]  band_q     = '0;
    logic signed [INTEG_W-1:0] integral_q = '0;
    logic signed [ERR_W-1:0]   last_err_q = '0;

    drive_t pending_drive[$];
    int     mismatches     = 0;
    int     items_sent     = 0;
    int     drives_checked = 0;
    int     cfg_writes     = 0;
    int     stall_left     = 0;
    int     idle_cycles    = 0;
    bit     quiet          = 1'b0;

    pid_position_controller dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Advances the shadow state by one control tick and returns the drive value.
    function automatic drive_t next_drive_power(pos_t target, pos_t measured);
        longint              err;
        longint              integ;
        longint              deriv;
        longint              abs_err;
        logic signed [127:0] e_x, i_x, d_x, gp_x, gi_x, gd_x;
        logic signed [127:0] sum;
        logic        [127:0] mag;
        err   = longint'(target) - longint'(measured);
        integ = longint'(integral_q) + err;
        if (integ > longint'(INTEG_MAX))
            integ = longint'(INTEG_MAX);
        if (integ < longint'(INTEG_MIN))
            integ = longint'(INTEG_MIN);
        abs_err = (err < 0) ? -err : err;
        if (abs_err > longint'(band_q) || err == 0)
            integ = 0;
        deriv      = err - longint'(last_err_q);
        integral_q = integ[INTEG_W-1:0];
        last_err_q = err[ERR_W-1:0];

        e_x  = err;
        i_x  = integ;
        d_x  = deriv;
        gp_x = gain_p_q;
        gi_x = gain_i_q;
        gd_x = gain_d_q;
        sum  = e_x * gp_x + i_x * gi_x + d_x * gd_x;

        // Shift the magnitude so the result truncates toward zero.
        if (sum < 0) begin
            mag = -sum;
            mag = mag >> GAIN_FRAC_BITS;
            return (mag > 128'd32768) ? drive_t'(DRIVE_MIN) : drive_t'(-mag[DRIVE_W-1:0]);
        end
        mag = sum;
        mag = mag >> GAIN_FRAC_BITS;
        return (mag > 128'd32767) ? drive_t'(DRIVE_MAX) : drive_t'(mag[DRIVE_W-1:0]);
    endfunction

    function automatic dir_row_t item_row(pos_t target, pos_t measured, bit known,
                                          drive_t drive);
        return '{ROW_ITEM, '0, '0, target, measured, known, drive};
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] index,
                                         logic [GAIN_W-1:0] data);
        return '{ROW_CFG, index, data, '0, '0, 1'b0, '0};
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick <= 2)
            return $urandom;
        // Mostly gains within +/-2.0 so that the output often stays unsaturated.
        return GAIN_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [GAIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_GAIN_P: gain_p_q = data;
            REG_GAIN_I: gain_i_q = data;
            REG_GAIN_D: gain_d_q = data;
            REG_BAND:   band_q   = data[BAND_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Stops sending and waits until every drive value in flight has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_item(input pos_t target, input pos_t measured,
                             input bit known, input drive_t drive);
        drive_t predicted;
        int     gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        cfg_valid <= 1'b0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_target_position   <= target;
        s_measured_position <= measured;
        do @(posedge aclk); while (!s_ready);
        predicted = next_drive_power(target, measured);
        pending_drive.push_back(known ? drive : predicted);
        items_sent++;
    endtask

    // Most errors fall inside the band so the integral builds up; the rest are zero,
    // just outside the band, or taken from the full position range.
    task automatic send_random_item();
        longint meas;
        longint delta;
        longint tgt;
        int     pick;
        pick = $urandom_range(0, 9);
        meas = longint'(pos_t'($urandom));
        if (pick <= 5)
            delta = longint'($urandom_range(0, band_q));
        else if (pick == 6)
            delta = 0;
        else if (pick == 7)
            delta = longint'(band_q) + $urandom_range(1, 3);
        else
            delta = longint'(pos_t'($urandom)) - meas;
        if (pick <= 7 && $urandom_range(0, 1) == 1)
            delta = -delta;
        tgt = meas + delta;
        if (tgt > longint'(POS_MAX) || tgt < longint'(POS_MIN))
            tgt = meas - delta;
        send_item(pos_t'(tgt), pos_t'(meas), 1'b0, '0);
    endtask

    always @(posedge aclk) begin : drive_monitor
        drive_t exp_drive;
        int     stall;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            if (pending_drive.size() == 0) begin
                report_mismatch($sformatf("drive_power %0d with no item expected",
                                          m_drive_power));
            end else begin
                exp_drive = pending_drive.pop_front();
                drives_checked++;
                if (m_drive_power !== exp_drive)
                    report_mismatch($sformatf("drive_power got %0d, expected %0d",
                                              m_drive_power, exp_drive));
            end
            stall = quiet ? 0 : $urandom_range(0, 4);
            stall_left <= stall;
            m_ready    <= (stall == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main_sequence
        dir_row_t rows[$];

        // Gains are zero after reset, so the output is zero whatever the error.
        rows.push_back(item_row(1000, -1000, 1, 0));
        rows.push_back(item_row(POS_MAX, POS_MIN, 1, 0));
        // Unit proportional gain, including both ends of the error range.
        rows.push_back(cfg_row(REG_GAIN_P, GAIN_ONE));
        rows.push_back(item_row(100, 0, 1, 100));
        rows.push_back(item_row(POS_MAX, POS_MIN, 1, 32767));
        rows.push_back(item_row(POS_MIN, POS_MAX, 1, -32768));
        rows.push_back(cfg_row(REG_GAIN_P, GAIN_NEG1));
        rows.push_back(item_row(7, 0, 1, -7));
        // A gain of one half shows truncation toward zero for negative sums.
        rows.push_back(cfg_row(REG_GAIN_P, GAIN_HALF));
        rows.push_back(item_row(0, 3, 1, -1));
        rows.push_back(item_row(1, 0, 1, 0));
        rows.push_back(item_row(0, 1, 1, 0));
        rows.push_back(cfg_row(REG_GAIN_P, GAIN_MAX));
        rows.push_back(item_row(1, 0, 1, 32767));
        rows.push_back(item_row(0, 1, 1, -32767));
        rows.push_back(cfg_row(REG_GAIN_P, GAIN_MIN));
        rows.push_back(item_row(1, 0, 1, -32768));
        rows.push_back(item_row(0, 1, 1, 32767));
        // Integral alone: it clears on a zero error and on an error beyond the band.
        rows.push_back(cfg_row(REG_GAIN_P, '0));
        rows.push_back(cfg_row(REG_GAIN_I, GAIN_ONE));
        rows.push_back(cfg_row(REG_BAND, 32'd10));
        rows.push_back(item_row(5, 0, 1, 5));
        rows.push_back(item_row(5, 0, 1, 10));
        rows.push_back(item_row(0, 0, 1, 0));
        rows.push_back(item_row(11, 0, 1, 0));
        rows.push_back(item_row(-10, 0, 1, -10));
        rows.push_back(item_row(-10, 0, 1, -20));
        // Derivative alone, starting from a last error of -10.
        rows.push_back(cfg_row(REG_GAIN_I, '0));
        rows.push_back(cfg_row(REG_GAIN_D, GAIN_ONE));
        rows.push_back(item_row(20, 0, 1, 30));
        rows.push_back(item_row(20, 0, 1, 0));
        rows.push_back(item_row(POS_MAX, POS_MIN, 1, 32767));
        rows.push_back(item_row(POS_MIN, POS_MAX, 1, -32768));
        // Every gain at its maximum with the widest band; the upper data bits are ignored.
        rows.push_back(cfg_row(REG_GAIN_P, GAIN_MAX));
        rows.push_back(cfg_row(REG_GAIN_I, GAIN_MAX));
        rows.push_back(cfg_row(REG_GAIN_D, GAIN_MAX));
        rows.push_back(cfg_row(REG_BAND, 32'hFFFF_FFFF));
        rows.push_back(item_row(POS_MAX, POS_MIN, 0, 0));
        rows.push_back(item_row(65535, 0, 0, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                wait_idle();
                write_reg(rows[r].index, rows[r].data);
            end else begin
                send_item(rows[r].target, rows[r].measured, rows[r].known, rows[r].drive);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            quiet = (ph % 3 == 2);
            case (ph)
                0: begin
                    write_reg(REG_GAIN_P, GAIN_MAX);
                    write_reg(REG_GAIN_I, GAIN_MAX);
                    write_reg(REG_GAIN_D, GAIN_MAX);
                    write_reg(REG_BAND, 32'hFFFF_0000);
                end
                1: begin
                    write_reg(REG_GAIN_P, GAIN_MIN);
                    write_reg(REG_GAIN_I, GAIN_MIN);
                    write_reg(REG_GAIN_D, GAIN_MIN);
                    write_reg(REG_BAND, 32'h0000_FFFF);
                end
                default: begin
                    write_reg(REG_GAIN_P, random_gain());
                    write_reg(REG_GAIN_I, random_gain());
                    write_reg(REG_GAIN_D, random_gain());
                    if ($urandom_range(0, 2) == 0)
                        write_reg(REG_BAND, $urandom);
                    else
                        write_reg(REG_BAND, $urandom_range(0, 4000));
                end
            endcase
            repeat (PHASE_ITEMS) send_random_item();
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d position items across %0d register writes, gains at both extremes.",
                 items_sent, cfg_writes);
        $display("Compared %0d drive_power items, %0d mismatches.", drives_checked, mismatches);
        if (mismatches == 0 && pending_drive.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/pidpc_pkg.sv
rtl/pid_position_controller.sv
tb/tb_top.sv
